// ----- rtl/rde_pkg.sv -----
// Shared types and constants for the reversible double-ended queue.
package rde_pkg;

  // Width of the operation code carried by an input beat.
  localparam int unsigned KIND_W = 3;

  // Operation codes of an input beat.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_REVERSE    = 3'd4
  } kind_e;

  // What one row of cells does in a cycle.
  typedef enum logic [1:0] {
    ROW_HOLD,
    ROW_PUSH_HEAD,
    ROW_POP_HEAD,
    ROW_PUSH_TAIL
  } row_op_e;

  // What a single cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN,
    CELL_LOAD
  } cell_op_e;

  // Control handed from the top level to a row.
  typedef struct packed {
    row_op_e op;
  } row_ctl_t;

endpackage

// ----- rtl/rde_if.sv -----
// Handshake channels for operation beats and result beats.
interface rde_in_if #(
  parameter int unsigned WORD_BITS = 32
) ();
  logic                      valid;
  logic                      ready;
  logic [rde_pkg::KIND_W-1:0] kind;
  logic [WORD_BITS-1:0]      word_in;

  modport source (output valid, output kind, output word_in, input ready);
  modport sink   (input valid, input kind, input word_in, output ready);
endinterface

interface rde_out_if #(
  parameter int unsigned WORD_BITS  = 32,
  parameter int unsigned COUNT_BITS = 5
) ();
  logic                  valid;
  logic                  ready;
  logic [WORD_BITS-1:0]  word_out;
  logic                  word_valid;
  logic [COUNT_BITS-1:0] entry_count;
  logic                  empty_flag;
  logic                  overflow_flag;

  modport source (output valid, output word_out, output word_valid, output entry_count,
                  output empty_flag, output overflow_flag, input ready);
  modport sink   (input valid, input word_out, input word_valid, input entry_count,
                  input empty_flag, input overflow_flag, output ready);
endinterface

// ----- rtl/reversible_double_ended_queue.sv -----
// Top level of the reversible double-ended queue.
// Bounded double-ended queue with a reverse command. Every operation beat (push or pop at
// either end, or reverse) yields exactly one result beat with the popped word, its valid bit,
// the entry count, an empty flag and an overflow flag. The queue is held twice, in two rows of
// DEPTH shifting cells: one row keeps the entries with the front in its first cell, the other
// with the back in its first cell, so every pop reads a fixed cell and every push either shifts
// a row or loads the one cell at the count. Reverse only swaps which row plays the front, and
// only while more than one entry is held. One operation is taken every clock cycle, as long as
// the output register is empty or its result is taken in the same cycle; the result is
// registered on acceptance. A push onto a full queue is dropped and flagged; a pop on an empty
// queue returns a zero word marked not valid. No clearing pass after reset.
module reversible_double_ended_queue #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rde_in_if.sink          req_i,
  rde_out_if.source       rsp_o
);

  localparam int unsigned CountBits = $clog2(DEPTH + 1);

  logic [CountBits-1:0] count_q, count_d;
  logic                 rev_q, rev_d;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 word_valid_q, word_valid_d;
  logic                 overflow_q, overflow_d;

  logic                 in_fire;
  logic                 full;
  logic                 empty;
  rde_pkg::row_op_e     front_op, back_op;
  rde_pkg::row_ctl_t    ctl_a, ctl_b;
  logic [WORD_BITS-1:0] head_a, head_b;
  logic [WORD_BITS-1:0] front_word, back_word;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign in_fire     = req_i.valid && req_i.ready;
  assign full        = (count_q == CountBits'(DEPTH));
  assign empty       = (count_q == '0);

  // Row A holds the front at its head unless reversed; row B the other way round.
  assign front_word = rev_q ? head_b : head_a;
  assign back_word  = rev_q ? head_a : head_b;

  // Decode the operation into row commands and the next result.
  always_comb begin
    front_op     = rde_pkg::ROW_HOLD;
    back_op      = rde_pkg::ROW_HOLD;
    count_d      = count_q;
    rev_d        = rev_q;
    word_d       = '0;
    word_valid_d = 1'b0;
    overflow_d   = 1'b0;
    if (in_fire) begin
      unique case (rde_pkg::kind_e'(req_i.kind))
        rde_pkg::KIND_PUSH_BACK: begin
          if (full) begin
            overflow_d = 1'b1;
          end else begin
            back_op  = rde_pkg::ROW_PUSH_HEAD;
            front_op = rde_pkg::ROW_PUSH_TAIL;
            count_d  = count_q + 1'b1;
          end
        end
        rde_pkg::KIND_PUSH_FRONT: begin
          if (full) begin
            overflow_d = 1'b1;
          end else begin
            front_op = rde_pkg::ROW_PUSH_HEAD;
            back_op  = rde_pkg::ROW_PUSH_TAIL;
            count_d  = count_q + 1'b1;
          end
        end
        rde_pkg::KIND_POP_BACK: begin
          if (!empty) begin
            back_op      = rde_pkg::ROW_POP_HEAD;
            word_d       = back_word;
            word_valid_d = 1'b1;
            count_d      = count_q - 1'b1;
          end
        end
        rde_pkg::KIND_POP_FRONT: begin
          if (!empty) begin
            front_op     = rde_pkg::ROW_POP_HEAD;
            word_d       = front_word;
            word_valid_d = 1'b1;
            count_d      = count_q - 1'b1;
          end
        end
        rde_pkg::KIND_REVERSE: begin
          if (count_q > CountBits'(1)) begin
            rev_d = !rev_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Map front and back commands onto the physical rows.
  always_comb begin
    ctl_a.op = rev_q ? back_op  : front_op;
    ctl_b.op = rev_q ? front_op : back_op;
  end

  rde_row #(
    .DEPTH      (DEPTH),
    .WORD_BITS  (WORD_BITS),
    .COUNT_BITS (CountBits)
  ) u_row_a (
    .clk_i   (clk_i),
    .ctl_i   (ctl_a),
    .count_i (count_q),
    .word_i  (req_i.word_in),
    .head_o  (head_a)
  );

  rde_row #(
    .DEPTH      (DEPTH),
    .WORD_BITS  (WORD_BITS),
    .COUNT_BITS (CountBits)
  ) u_row_b (
    .clk_i   (clk_i),
    .ctl_i   (ctl_b),
    .count_i (count_q),
    .word_i  (req_i.word_in),
    .head_o  (head_b)
  );

  // Queue state and the valid bit of the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      rev_q   <= rev_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      word_q       <= word_d;
      word_valid_q <= word_valid_d;
      overflow_q   <= overflow_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.word_out      = word_q;
  assign rsp_o.word_valid    = word_valid_q;
  assign rsp_o.entry_count   = count_q;
  assign rsp_o.empty_flag    = (count_q == '0);
  assign rsp_o.overflow_flag = overflow_q;

  // The count never exceeds the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CountBits'(DEPTH))
    else $error("entry count above depth");

  // A result never reports both a popped word and a dropped push.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rsp_o.valid |-> !(rsp_o.word_valid && rsp_o.overflow_flag))
    else $error("pop and overflow in one result");

  // Every accepted beat leaves a result waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> rsp_o.valid)
    else $error("accepted beat without result");

  // The direction only flips after a reverse taken with more than one entry held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !$stable(rev_q) |-> ($past(in_fire) && $past(count_q) > CountBits'(1)))
    else $error("unexpected direction change");

endmodule

// ----- rtl/rde_cell.sv -----
// One storage cell of a row: holds a word, or takes it from a neighbor or the load bus.
module rde_cell #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                     clk_i,
  input  rde_pkg::cell_op_e        op_i,
  input  logic [WORD_BITS-1:0]     lo_i,
  input  logic [WORD_BITS-1:0]     hi_i,
  input  logic [WORD_BITS-1:0]     word_i,
  output logic [WORD_BITS-1:0]     q_o
);

  logic [WORD_BITS-1:0] data_q;

  // Payload only, so no reset.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      rde_pkg::CELL_HOLD: data_q <= data_q;
      rde_pkg::CELL_UP:   data_q <= lo_i;
      rde_pkg::CELL_DOWN: data_q <= hi_i;
      rde_pkg::CELL_LOAD: data_q <= word_i;
      default:            data_q <= data_q;
    endcase
  end

  assign q_o = data_q;

endmodule

// ----- rtl/rde_row.sv -----
// A row of cells holding the queue in order from its head cell outward.
module rde_row #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned WORD_BITS  = 32,
  parameter int unsigned COUNT_BITS = 5
) (
  input  logic                    clk_i,
  input  rde_pkg::row_ctl_t       ctl_i,
  input  logic [COUNT_BITS-1:0]   count_i,
  input  logic [WORD_BITS-1:0]    word_i,
  output logic [WORD_BITS-1:0]    head_o
);

  logic [WORD_BITS-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rde_pkg::cell_op_e    op;
    logic [WORD_BITS-1:0] lo;
    logic [WORD_BITS-1:0] hi;

    // The head cell takes the new word on a head push; the last cell keeps its own word.
    if (i == 0) begin : g_first
      assign lo = word_i;
    end else begin : g_inner_lo
      assign lo = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign hi = data[i];
    end else begin : g_inner_hi
      assign hi = data[i+1];
    end

    // Per-cell decode of the row operation; a tail push loads only the cell at the count.
    always_comb begin
      unique case (ctl_i.op)
        rde_pkg::ROW_PUSH_HEAD: op = rde_pkg::CELL_UP;
        rde_pkg::ROW_POP_HEAD:  op = rde_pkg::CELL_DOWN;
        rde_pkg::ROW_PUSH_TAIL: op = (count_i == COUNT_BITS'(i)) ? rde_pkg::CELL_LOAD
                                                                 : rde_pkg::CELL_HOLD;
        default:                op = rde_pkg::CELL_HOLD;
      endcase
    end

    rde_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .lo_i   (lo),
      .hi_i   (hi),
      .word_i (word_i),
      .q_o    (data[i])
    );
  end

  assign head_o = data[0];

endmodule

// ----- tb/reversible_double_ended_queue_tb.sv -----
// Self-checking testbench for the reversible double-ended queue, with a scoreboard class.
module reversible_double_ended_queue_tb;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned COUNT_BITS  = 5;
  localparam int unsigned KIND_W      = rde_pkg::KIND_W;
  localparam int unsigned LONG_HOLD   = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SEGMENTS    = 14;
  localparam int unsigned SEG_ITEMS   = 100;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [WORD_BITS-1:0]  word;
    logic                  word_valid;
    logic [COUNT_BITS-1:0] count;
    logic                  empty;
    logic                  overflow;
  } deque_result_t;

  // How the random operations lean: toward filling, draining, or neither.
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;

  // Tracks the queue contents and holds the results still owed by the block.
  class deque_scoreboard;
    logic [WORD_BITS-1:0]  ring [DEPTH];
    logic [3:0]            head;
    logic [COUNT_BITS-1:0] held;
    logic                  flipped;
    deque_result_t         owed [$];
    int unsigned           mismatches;

    function new();
      head       = '0;
      held       = '0;
      flipped    = 1'b0;
      mismatches = 0;
    endfunction

    // Physical back end: the slot just past the last entry.
    function logic add_at_tail(logic [WORD_BITS-1:0] w);
      logic [3:0] idx;
      if (held == DEPTH) return 1'b0;
      idx = head + held[3:0];
      ring[idx] = w;
      held++;
      return 1'b1;
    endfunction

    // Physical front end: the head moves down one slot.
    function logic add_at_head(logic [WORD_BITS-1:0] w);
      if (held == DEPTH) return 1'b0;
      head = head - 4'd1;
      ring[head] = w;
      held++;
      return 1'b1;
    endfunction

    function logic take_from_tail(output logic [WORD_BITS-1:0] w);
      logic [3:0] idx;
      w = '0;
      if (held == 0) return 1'b0;
      idx = head + held[3:0] - 4'd1;
      w = ring[idx];
      held--;
      return 1'b1;
    endfunction

    function logic take_from_head(output logic [WORD_BITS-1:0] w);
      w = '0;
      if (held == 0) return 1'b0;
      w = ring[head];
      head = head + 4'd1;
      held--;
      return 1'b1;
    endfunction

    // Applies one accepted operation beat and queues the result it must produce.
    function void note_op(logic [KIND_W-1:0] kind, logic [WORD_BITS-1:0] w);
      deque_result_t res;
      logic [WORD_BITS-1:0] got;
      logic ok;
      res = '0;
      got = '0;
      ok  = 1'b0;
      case (kind)
        rde_pkg::KIND_PUSH_BACK:  res.overflow = flipped ? !add_at_head(w) : !add_at_tail(w);
        rde_pkg::KIND_PUSH_FRONT: res.overflow = flipped ? !add_at_tail(w) : !add_at_head(w);
        rde_pkg::KIND_POP_BACK:   ok = flipped ? take_from_head(got) : take_from_tail(got);
        rde_pkg::KIND_POP_FRONT:  ok = flipped ? take_from_tail(got) : take_from_head(got);
        rde_pkg::KIND_REVERSE: begin
          if (held > 1) flipped = !flipped;
        end
        default: ;
      endcase
      res.word       = ok ? got : '0;
      res.word_valid = ok;
      res.count      = held;
      res.empty      = (held == 0);
      owed.push_back(res);
    endfunction

    // Prints one line per mismatch and counts every one.
    task report_mismatch(string field, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
      mismatches++;
      $display("ERROR: deque result %s got %0h, expected %0h at %0t", field, got, want,
               $realtime);
    endtask

    // Compares one result beat with the oldest owed result, field by field.
    task check_result(deque_result_t got);
      deque_result_t want;
      if (owed.size() == 0) begin
        report_mismatch("beat with nothing owed", got.word, '0);
      end else begin
        want = owed[0];
        owed.delete(0);
        if (got.word !== want.word) report_mismatch("word_out", got.word, want.word);
        if (got.word_valid !== want.word_valid)
          report_mismatch("word_valid", WORD_BITS'(got.word_valid),
                          WORD_BITS'(want.word_valid));
        if (got.count !== want.count)
          report_mismatch("entry_count", WORD_BITS'(got.count), WORD_BITS'(want.count));
        if (got.empty !== want.empty)
          report_mismatch("empty_flag", WORD_BITS'(got.empty), WORD_BITS'(want.empty));
        if (got.overflow !== want.overflow)
          report_mismatch("overflow_flag", WORD_BITS'(got.overflow), WORD_BITS'(want.overflow));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rde_in_if  #(.WORD_BITS(WORD_BITS))                         req_if ();
  rde_out_if #(.WORD_BITS(WORD_BITS), .COUNT_BITS(COUNT_BITS)) rsp_if ();

  reversible_double_ended_queue #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  deque_scoreboard sb = new();
  int unsigned     cycles = 0;
  logic            no_idle = 1'b0;
  logic            hold_req = 1'b0;

  // Clock with a period of 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("reversible_double_ended_queue: mismatch");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    deque_result_t got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.note_op(req_if.kind, req_if.word_in);
      if (rsp_if.valid && rsp_if.ready) begin
        got.word       = rsp_if.word_out;
        got.word_valid = rsp_if.word_valid;
        got.count      = rsp_if.entry_count;
        got.empty      = rsp_if.empty_flag;
        got.overflow   = rsp_if.overflow_flag;
        sb.check_result(got);
      end
    end
  end

  // Result side: random stalls per beat, and one long hold-off on request.
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 7);
        if (stall != 0) begin
          rsp_if.ready = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      @(negedge clk_i);
    end
  end

  // Offers one operation beat after a random gap and returns once it is taken.
  task send_op(logic [KIND_W-1:0] kind, logic [WORD_BITS-1:0] w);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   = 1'b1;
    req_if.kind    = kind;
    req_if.word_in = w;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Holds the operation side until every owed result has come back.
  task wait_drained();
    req_if.valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
  endtask

  // Draws an operation code leaning as the mix asks; spare codes now and then.
  function logic [KIND_W-1:0] pick_kind(op_mix_e mix);
    int unsigned r;
    int unsigned push_pct;
    logic front;
    r = $urandom_range(0, 99);
    front = 1'($urandom_range(0, 1));
    push_pct = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 30 : 50;
    if (r < 3)
      return KIND_W'($urandom_range(int'(rde_pkg::KIND_REVERSE) + 1, (1 << KIND_W) - 1));
    if (r < 13) return rde_pkg::KIND_REVERSE;
    if ($urandom_range(0, 99) < push_pct)
      return front ? rde_pkg::KIND_PUSH_FRONT : rde_pkg::KIND_PUSH_BACK;
    return front ? rde_pkg::KIND_POP_FRONT : rde_pkg::KIND_POP_BACK;
  endfunction

  // Mostly random words, with the all-zero and all-one extremes mixed in.
  function logic [WORD_BITS-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.kind    = rde_pkg::KIND_PUSH_BACK;
    req_if.word_in = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty pops, reverse on empty and on one entry, fill to full, overflow at both
    // ends, reverse when full, a pop at each end of the reversed queue, and a spare code.
    send_op(rde_pkg::KIND_POP_BACK, '1);
    send_op(rde_pkg::KIND_POP_FRONT, '0);
    send_op(rde_pkg::KIND_REVERSE, '0);
    send_op(rde_pkg::KIND_PUSH_BACK, '0);
    send_op(rde_pkg::KIND_REVERSE, '1);
    send_op(rde_pkg::KIND_PUSH_FRONT, '1);
    for (int i = 0; i < 13; i++)
      send_op((i % 2) ? rde_pkg::KIND_PUSH_FRONT : rde_pkg::KIND_PUSH_BACK,
              (i == 0) ? 32'h8000_0001 : $urandom);
    send_op(rde_pkg::KIND_PUSH_BACK, '1);
    send_op(rde_pkg::KIND_PUSH_FRONT, '1);
    send_op(rde_pkg::KIND_PUSH_BACK, 32'h5555_aaaa);
    send_op(rde_pkg::KIND_REVERSE, '0);
    send_op(rde_pkg::KIND_POP_BACK, '0);
    send_op(rde_pkg::KIND_POP_FRONT, '0);
    send_op({KIND_W{1'b1}}, '1);
    wait_drained();

    // Random segments that lean toward filling, draining or neither in turn.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      no_idle = (seg == 1 || seg == 2) ? 1'b1 : ($urandom_range(0, 3) == 0);
      if (seg == 2) hold_req = 1'b1;
      if (seg == 5 || seg == 10) wait_drained();
      for (int n = 0; n < SEG_ITEMS; n++)
        send_op(pick_kind(op_mix_e'(seg % 3)), pick_word());
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("reversible_double_ended_queue: match");
    end else begin
      $display("reversible_double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule
